FILE: sv/minimum_spanning_tree_kruskal_defines.svh
// ----------------------------------------------------------------------------
// Minimum spanning tree engine: assertion macros
// Shared concurrent assertion forms, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef MINIMUM_SPANNING_TREE_KRUSKAL_DEFINES_SVH
`define MINIMUM_SPANNING_TREE_KRUSKAL_DEFINES_SVH

// Property holds at every clock edge outside reset.
`define MSTK_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("mstk assertion failed");

// Consequent holds in the cycle after the antecedent.
`define MSTK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mstk assertion failed");

`endif

FILE: sv/mstk_pkg.sv
// ----------------------------------------------------------------------------
// mstk_pkg
// Types and constants shared by the spanning tree controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mstk_pkg;

   localparam int VERTEX_BITS = 6;
   localparam int CFG_BITS    = 7;
   localparam int RANK_BITS   = 3;

   typedef enum logic [15:0] {
      ST_LOAD        = 16'h0001,
      ST_CLEAR       = 16'h0002,
      ST_CHECK       = 16'h0004,
      ST_SCAN        = 16'h0008,
      ST_SCAN_WAIT   = 16'h0010,
      ST_PICK        = 16'h0020,
      ST_FIND_A      = 16'h0040,
      ST_FIND_A_WAIT = 16'h0080,
      ST_FIND_B      = 16'h0100,
      ST_FIND_B_WAIT = 16'h0200,
      ST_JOIN        = 16'h0400,
      ST_JOIN2       = 16'h0800,
      ST_EMIT_RD     = 16'h1000,
      ST_EMIT_LD     = 16'h2000,
      ST_EMIT_HOLD   = 16'h4000,
      ST_EMPTY_LD    = 16'h8000
   } state_type;

   typedef struct packed {
      logic load_en;
      logic clear_step;
      logic scan_start;
      logic scan_read;
      logic take_best;
      logic mark_drop;
      logic walk_a;
      logic node_read;
      logic walk_follow;
      logic cap_a;
      logic cap_b;
      logic join1;
      logic join2;
      logic res_read;
      logic out_load;
      logic out_empty;
      logic out_valid;
      logic run_done;
   } cmd_type;

   typedef struct packed {
      logic last_accept;
      logic clr_last;
      logic limit_reached;
      logic found_zero;
      logic scan_last;
      logic best_valid;
      logic best_bad;
      logic node_is_root;
      logic roots_equal;
      logic ranks_equal;
      logic out_final;
   } status_type;

endpackage

`default_nettype wire

FILE: sv/mstk_ctrl.sv
// ----------------------------------------------------------------------------
// mstk_ctrl
// Sequencer: load, clear, selection scans, root walks, joins and emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mstk_ctrl
   import mstk_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire status_type status,
   input  wire logic       rsp_tready,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            cmd.load_en = 1'b1;
            if (status.last_accept) state_in = ST_CLEAR;
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clr_last) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.limit_reached) begin
               state_in = status.found_zero ? ST_EMPTY_LD : ST_EMIT_RD;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_read = 1'b1;
            if (status.scan_last) state_in = ST_SCAN_WAIT;
         end
         ST_SCAN_WAIT: state_in = ST_PICK;
         ST_PICK: begin
            if (!status.best_valid) begin
               state_in = status.found_zero ? ST_EMPTY_LD : ST_EMIT_RD;
            end else if (status.best_bad) begin
               cmd.take_best = 1'b1;
               cmd.mark_drop = 1'b1;
               state_in      = ST_CHECK;
            end else begin
               cmd.take_best = 1'b1;
               cmd.walk_a    = 1'b1;
               state_in      = ST_FIND_A;
            end
         end
         ST_FIND_A: begin
            cmd.node_read = 1'b1;
            state_in      = ST_FIND_A_WAIT;
         end
         ST_FIND_A_WAIT: begin
            if (status.node_is_root) begin
               cmd.cap_a = 1'b1;
               state_in  = ST_FIND_B;
            end else begin
               cmd.walk_follow = 1'b1;
               state_in        = ST_FIND_A;
            end
         end
         ST_FIND_B: begin
            cmd.node_read = 1'b1;
            state_in      = ST_FIND_B_WAIT;
         end
         ST_FIND_B_WAIT: begin
            if (status.node_is_root) begin
               cmd.cap_b = 1'b1;
               state_in  = ST_JOIN;
            end else begin
               cmd.walk_follow = 1'b1;
               state_in        = ST_FIND_B;
            end
         end
         ST_JOIN: begin
            if (status.roots_equal) begin
               state_in = ST_CHECK;
            end else begin
               cmd.join1 = 1'b1;
               state_in  = status.ranks_equal ? ST_JOIN2 : ST_CHECK;
            end
         end
         ST_JOIN2: begin
            cmd.join2 = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_EMIT_RD: begin
            cmd.res_read = 1'b1;
            state_in     = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            cmd.out_load = 1'b1;
            state_in     = ST_EMIT_HOLD;
         end
         ST_EMPTY_LD: begin
            cmd.out_empty = 1'b1;
            state_in      = ST_EMIT_HOLD;
         end
         ST_EMIT_HOLD: begin
            cmd.out_valid = 1'b1;
            if (rsp_tready) begin
               if (status.out_final) begin
                  cmd.run_done = 1'b1;
                  state_in     = ST_LOAD;
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

endmodule

`default_nettype wire

FILE: sv/mstk_datapath.sv
// ----------------------------------------------------------------------------
// mstk_datapath
// Edge store, selection compare, union-find node memory, result buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mstk_datapath
   import mstk_pkg::*;
#(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_EDGES    = 256,
   parameter int WEIGHT_BITS  = 16,
   localparam int DATA_BITS   = ((2 * VERTEX_BITS + WEIGHT_BITS + 7) / 8) * 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   output status_type                  status,
   input  wire logic                   req_tvalid,
   input  wire logic [DATA_BITS-1:0]   req_tdata,
   input  wire logic                   req_tlast,
   input  wire logic                   csr_wr_en,
   input  wire logic [CFG_BITS-1:0]    csr_wr_data,
   output logic      [DATA_BITS-1:0]   rsp_tdata,
   output logic      [1:0]             rsp_tuser,
   output logic                        rsp_tlast
);

   localparam int EW        = 2 * VERTEX_BITS + WEIGHT_BITS;
   localparam int VB        = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int IDXB      = $clog2(MAX_EDGES);
   localparam int CNTB      = $clog2(MAX_EDGES + 1);
   localparam int NW        = RANK_BITS + VB;

   logic [CFG_BITS-1:0] vcount_ff;
   logic [CFG_BITS-1:0] eff_nv, limit;

   logic [EW-1:0] edge_mem [MAX_EDGES];
   logic [NW-1:0] node_mem [MAX_VERTICES];
   logic [EW-1:0] res_mem  [MAX_VERTICES];

   logic [CNTB-1:0] total_ff;
   logic            drop_ff;
   logic [IDXB-1:0] scan_addr_ff, rd_idx_ff, best_idx_ff, prev_idx_ff;
   logic            rd_valid_ff, best_valid_ff, have_prev_ff;
   logic [EW-1:0]   rd_q_ff, best_ff, res_q_ff, out_edge_ff;
   logic [WEIGHT_BITS-1:0] prev_w_ff;
   logic [VB-1:0]   clr_ff, walk_ff, root_a_ff, root_b_ff, found_ff, k_ff;
   logic [RANK_BITS-1:0] rank_a_ff, rank_b_ff;
   logic [NW-1:0]   node_q_ff;
   logic            out_present_ff, out_final_ff, out_err_ff;

   logic [VERTEX_BITS-1:0] in_src, in_dst, best_a, best_b;
   logic                   accept, in_ok, upd, gt_prev, lt_best;
   logic signed [WEIGHT_BITS-1:0] rd_w, best_w, prev_w;
   logic [VB-1:0]          node_parent;
   logic [RANK_BITS-1:0]   node_rank;

   assign eff_nv = (vcount_ff > CFG_BITS'(MAX_VERTICES)) ? CFG_BITS'(MAX_VERTICES) : vcount_ff;
   assign limit  = (eff_nv == '0) ? '0 : eff_nv - CFG_BITS'(1);

   assign in_src = req_tdata[VERTEX_BITS-1:0];
   assign in_dst = req_tdata[2*VERTEX_BITS-1:VERTEX_BITS];
   assign accept = req_tvalid & cmd.load_en;
   assign in_ok  = (CFG_BITS'(in_src) < eff_nv) && (CFG_BITS'(in_dst) < eff_nv)
                   && (total_ff < CNTB'(MAX_EDGES));

   assign best_a = best_ff[VERTEX_BITS-1:0];
   assign best_b = best_ff[2*VERTEX_BITS-1:VERTEX_BITS];
   assign rd_w   = $signed(rd_q_ff[EW-1:2*VERTEX_BITS]);
   assign best_w = $signed(best_ff[EW-1:2*VERTEX_BITS]);
   assign prev_w = $signed(prev_w_ff);

   assign gt_prev = !have_prev_ff || (rd_w > prev_w)
                    || ((rd_w == prev_w) && (rd_idx_ff > prev_idx_ff));
   assign lt_best = !best_valid_ff || (rd_w < best_w)
                    || ((rd_w == best_w) && (rd_idx_ff < best_idx_ff));
   assign upd     = rd_valid_ff && gt_prev && lt_best;

   assign node_parent = node_q_ff[VB-1:0];
   assign node_rank   = node_q_ff[NW-1:VB];

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff     <= CFG_BITS'(64);
         total_ff      <= '0;
         drop_ff       <= 1'b0;
         scan_addr_ff  <= '0;
         rd_valid_ff   <= 1'b0;
         best_valid_ff <= 1'b0;
         have_prev_ff  <= 1'b0;
         clr_ff        <= '0;
         found_ff      <= '0;
         k_ff          <= '0;
      end else begin
         if (csr_wr_en) vcount_ff <= csr_wr_data;
         if (accept && in_ok) total_ff <= total_ff + CNTB'(1);
         if ((accept && !in_ok) || cmd.mark_drop) drop_ff <= 1'b1;
         if (cmd.scan_start) scan_addr_ff <= '0;
         else if (cmd.scan_read) scan_addr_ff <= scan_addr_ff + IDXB'(1);
         rd_valid_ff <= cmd.scan_read;
         if (cmd.scan_start) best_valid_ff <= 1'b0;
         else if (upd) best_valid_ff <= 1'b1;
         if (cmd.take_best) have_prev_ff <= 1'b1;
         if (cmd.clear_step) clr_ff <= clr_ff + VB'(1);
         if (cmd.join1) found_ff <= found_ff + VB'(1);
         if (cmd.out_load) k_ff <= k_ff + VB'(1);
         if (cmd.run_done) begin
            total_ff     <= '0;
            drop_ff      <= 1'b0;
            have_prev_ff <= 1'b0;
            clr_ff       <= '0;
            found_ff     <= '0;
            k_ff         <= '0;
         end
      end
   end

   // edge store
   always_ff @(posedge clock) begin
      if (accept && in_ok) edge_mem[total_ff[IDXB-1:0]] <= req_tdata[EW-1:0];
      if (cmd.scan_read) rd_q_ff <= edge_mem[scan_addr_ff];
   end

   // union-find nodes: {rank, parent}
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         node_mem[clr_ff] <= {RANK_BITS'(0), clr_ff};
      end else if (cmd.join1) begin
         if (rank_a_ff < rank_b_ff) node_mem[root_a_ff] <= {rank_a_ff, root_b_ff};
         else                       node_mem[root_b_ff] <= {rank_b_ff, root_a_ff};
      end else if (cmd.join2) begin
         node_mem[root_a_ff] <= {rank_a_ff + RANK_BITS'(1), root_a_ff};
      end
      if (cmd.node_read) node_q_ff <= node_mem[walk_ff];
   end

   // result buffer
   always_ff @(posedge clock) begin
      if (cmd.join1) res_mem[found_ff] <= best_ff;
      if (cmd.res_read) res_q_ff <= res_mem[k_ff];
   end

   // payload
   always_ff @(posedge clock) begin
      rd_idx_ff <= scan_addr_ff;
      if (upd) begin
         best_ff     <= rd_q_ff;
         best_idx_ff <= rd_idx_ff;
      end
      if (cmd.take_best) begin
         prev_w_ff   <= best_ff[EW-1:2*VERTEX_BITS];
         prev_idx_ff <= best_idx_ff;
      end
      if (cmd.walk_a) walk_ff <= best_a[VB-1:0];
      else if (cmd.walk_follow) walk_ff <= node_parent;
      else if (cmd.cap_a) walk_ff <= best_b[VB-1:0];
      if (cmd.cap_a) begin
         root_a_ff <= walk_ff;
         rank_a_ff <= node_rank;
      end
      if (cmd.cap_b) begin
         root_b_ff <= walk_ff;
         rank_b_ff <= node_rank;
      end
      if (cmd.out_load) begin
         out_edge_ff    <= res_q_ff;
         out_present_ff <= 1'b1;
         out_final_ff   <= (k_ff + VB'(1)) == found_ff;
         out_err_ff     <= drop_ff;
      end else if (cmd.out_empty) begin
         out_edge_ff    <= '0;
         out_present_ff <= 1'b0;
         out_final_ff   <= 1'b1;
         out_err_ff     <= drop_ff;
      end
   end

   assign rsp_tdata = DATA_BITS'(out_edge_ff);
   assign rsp_tuser = {out_err_ff, out_present_ff};
   assign rsp_tlast = out_final_ff;

   always_comb begin
      status.last_accept   = accept && req_tlast;
      status.clr_last      = clr_ff == VB'(MAX_VERTICES - 1);
      status.limit_reached = (CFG_BITS'(found_ff) >= limit) || (total_ff == '0);
      status.found_zero    = found_ff == '0;
      status.scan_last     = (CNTB'(scan_addr_ff) + CNTB'(1)) == total_ff;
      status.best_valid    = best_valid_ff;
      status.best_bad      = (CFG_BITS'(best_a) >= eff_nv) || (CFG_BITS'(best_b) >= eff_nv);
      status.node_is_root  = node_parent == walk_ff;
      status.roots_equal   = root_a_ff == root_b_ff;
      status.ranks_equal   = rank_a_ff == rank_b_ff;
      status.out_final     = out_final_ff;
   end

endmodule

`default_nettype wire

FILE: sv/minimum_spanning_tree_kruskal.sv
// ----------------------------------------------------------------------------
// minimum_spanning_tree_kruskal
// Kruskal spanning forest engine with union by rank over a stored edge list.
// ----------------------------------------------------------------------------
// Usage:
//  req_* carries one edge per transaction; req_tlast marks the graph's last
//  edge. Edges load at one per cycle while req_tready is high. Edges with an
//  endpoint at or above vertex_count, or beyond MAX_EDGES, are dropped and
//  flagged in rsp_tuser[1] of every result of that graph.
//  After the last edge req_tready drops for the whole run: a node clear over
//  all MAX_VERTICES nodes, then per edge taken in weight order one selection
//  scan over the E stored edges, a root walk from each endpoint and a join
//  when the roots differ. The repeated scans over the edge store set the run
//  time. Results then leave one at a time on rsp_*, rsp_tlast on the last;
//  each result is loaded only once the one before is taken, and
//  an empty forest gives one result with rsp_tuser[0] low.
//  rsp_tvalid holds with stable data while rsp_tready is low; the block
//  waits. Reset (synchronous) empties the store and sets vertex_count to 64.
//  csr_wr_en writes vertex_count; write only while loading is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module minimum_spanning_tree_kruskal
   import mstk_pkg::*;
#(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_EDGES    = 256,
   parameter int WEIGHT_BITS  = 16,
   localparam int DATA_BITS   = ((2 * VERTEX_BITS + WEIGHT_BITS + 7) / 8) * 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // src_vertex[5:0], dest_vertex[11:6], edge_weight, zero pad
   input  wire logic [DATA_BITS-1:0] req_tdata,
   input  wire logic                 req_tlast,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // tree_src[5:0], tree_dest[11:6], tree_weight, zero pad
   output logic      [DATA_BITS-1:0] rsp_tdata,
   // edge_present[0], input_error[1]
   output logic      [1:0]           rsp_tuser,
   output logic                      rsp_tlast,
   input  wire logic                 csr_wr_en,
   input  wire logic [CFG_BITS-1:0]  csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   mstk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .status     (status),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   mstk_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_tvalid  (req_tvalid),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   assign req_tready = cmd.load_en;
   assign rsp_tvalid = cmd.out_valid;

endmodule

`default_nettype wire

FILE: sv/mstk_checker.sv
// ----------------------------------------------------------------------------
// mstk_checker
// Port-level temporal checks on the spanning tree engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "minimum_spanning_tree_kruskal_defines.svh"

module mstk_checker #(
   parameter int DATA_BITS = 32
) (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_tvalid,
   input wire logic                 req_tready,
   input wire logic                 req_tlast,
   input wire logic                 rsp_tvalid,
   input wire logic                 rsp_tready,
   input wire logic                 rsp_tlast,
   input wire logic [DATA_BITS-1:0] rsp_tdata
);

   `MSTK_ASSERT(a_no_overlap, clock, reset, !(req_tready && rsp_tvalid))
   `MSTK_ASSERT_NEXT(a_run_blocks_load, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready)
   `MSTK_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `MSTK_ASSERT_NEXT(a_last_ends_run, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast, !rsp_tvalid && req_tready)

endmodule

bind minimum_spanning_tree_kruskal mstk_checker #(.DATA_BITS(DATA_BITS)) u_mstk_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tlast  (rsp_tlast),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
